// ===== hw/rtl/sound_reactive_wave_pixels_assert.svh =====
// Assertion macros used by the checker of the sound reactive wave pixel block
`ifndef SOUND_REACTIVE_WAVE_PIXELS_ASSERT_SVH
`define SOUND_REACTIVE_WAVE_PIXELS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is active
`define SRWP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is active
`define SRWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/srwp_pkg.sv =====
// Types, constants and build-time table functions of the sound reactive wave pixel block
package srwp_pkg;

    localparam int unsigned ADC_MAX     = 4095;
    localparam int unsigned THR_RESET   = 2100;
    localparam int unsigned HOLD_RESET  = 1000;
    localparam int unsigned HUE_FULL    = 23040;
    localparam int unsigned HUE_SECTOR  = 3840;
    localparam int unsigned DIV_STEPS   = 13;

    localparam longint Q_TWO_PI         = 411775;
    localparam longint Q_PI             = 205887;
    localparam longint Q_HALF_PI        = 102944;
    localparam longint Q_ONE            = 65536;
    localparam longint FRAME_ANGLE_SUM  = 411566;
    localparam longint DIST_TO_ANGLE    = 384;
    localparam int unsigned DIST_SCALE  = 16384;

    localparam logic [1:0] CFG_LOUD_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_HOLD_MS        = 2'd1;

    typedef struct packed {
        logic [11:0] adc_sample;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [4:0] pixel_index;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last_pixel;
    } result_t;

    typedef struct packed {
        logic [3:0]  frame;
        logic [11:0] intensity;
        logic [14:0] sample_hue;
    } job_t;

    function automatic int unsigned isqrt_c(input int unsigned n);
        int unsigned num;
        int unsigned res;
        int unsigned bit_v;
        num   = n;
        res   = 0;
        bit_v = 32'd1 << 30;
        while (bit_v > num)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (num >= res + bit_v)
            begin
                num = num - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Wave level in Q0.12 for an angle in Q.16 radians (Taylor sine to x^9)
    function automatic logic [11:0] wave_c(input longint ang);
        longint r;
        longint s;
        longint w;
        longint unsigned x, x2, x3, x5, x7, x9;
        logic neg;
        r = ang % Q_TWO_PI;
        if (r < 0)
            r = r + Q_TWO_PI;
        if (r > Q_PI)
            r = r - Q_TWO_PI;
        if (r > Q_HALF_PI)
            r = Q_PI - r;
        if (r < -Q_HALF_PI)
            r = -Q_PI - r;
        neg = (r < 0);
        x  = longint'(neg ? -r : r);
        x2 = (x * x) >> 16;
        x3 = (x2 * x) >> 16;
        x5 = (x3 * x2) >> 16;
        x7 = (x5 * x2) >> 16;
        x9 = (x7 * x2) >> 16;
        s = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120)
            - longint'(x7 / 5040) + longint'(x9 / 362880);
        if (s < 0)
            s = 0;
        if (s > Q_ONE)
            s = Q_ONE;
        if (neg)
            s = -s;
        w = (s + Q_ONE) >>> 5;
        if (w > 4095)
            w = 4095;
        return 12'(w);
    endfunction

endpackage

// ===== hw/rtl/srwp_fifo.sv =====
// Small register queue used between the front and back and on the result side
module srwp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/srwp_front.sv =====
// Front part: registers, arming state, intensity divider and base hue per sample
module srwp_front #(
    parameter int FRAME_COUNT = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srwp_pkg::item_t     item,
    output logic                full,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                jq_wr,
    output srwp_pkg::job_t      jq_data,
    input  logic                jq_full
);
    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

    state_t      state_reg;
    logic [11:0] thr_reg;
    logic [15:0] hold_reg;
    logic        active_reg;
    logic [3:0]  frame_reg;
    logic [31:0] last_reg;
    logic [11:0] samp_reg;
    logic        loud_reg;
    logic [12:0] rem_reg;
    logic [11:0] div_reg;
    logic [12:0] quo_reg;
    logic [3:0]  cnt_reg;
    logic [26:0] prod_reg;
    logic [15:0] est_reg;
    logic [14:0] hue_reg;

    logic        accept;
    logic        loud;
    logic        quiet_long;
    logic        rem_ge;
    logic [12:0] rem_sub;
    logic [26:0] est_back;
    logic [11:0] intensity;

    assign full       = (state_reg != ST_IDLE);
    assign accept     = push && !full;
    assign loud       = (item.adc_sample > thr_reg);
    assign quiet_long = ((item.time_ms - last_reg) > {16'd0, hold_reg});
    assign rem_ge     = (rem_reg >= {1'b0, div_reg});
    assign rem_sub    = rem_ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;
    assign est_back   = 27'(est_reg) * 27'(srwp_pkg::ADC_MAX);
    assign intensity  = !loud_reg ? 12'd0 :
                        (quo_reg > 13'(srwp_pkg::ADC_MAX)) ? 12'(srwp_pkg::ADC_MAX) :
                        quo_reg[11:0];

    assign jq_wr              = (state_reg == ST_EMIT) && !jq_full;
    assign jq_data.frame      = frame_reg;
    assign jq_data.intensity  = intensity;
    assign jq_data.sample_hue = hue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            thr_reg    <= 12'(srwp_pkg::THR_RESET);
            hold_reg   <= 16'(srwp_pkg::HOLD_RESET);
            active_reg <= 1'b0;
            frame_reg  <= '0;
            last_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    srwp_pkg::CFG_LOUD_THRESHOLD: thr_reg  <= cfg_data[11:0];
                    srwp_pkg::CFG_HOLD_MS:        hold_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (loud)
                        begin
                            active_reg <= 1'b1;
                            last_reg   <= item.time_ms;
                        end
                        else if (quiet_long)
                        begin
                            active_reg <= 1'b0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'(srwp_pkg::DIV_STEPS - 1))
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!jq_full)
                    begin
                        if (active_reg)
                            frame_reg <= (frame_reg == 4'(FRAME_COUNT - 1)) ? '0
                                                                            : frame_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath: restoring division one quotient bit a cycle, hue scaling alongside
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg <= item.adc_sample;
            loud_reg <= loud;
            rem_reg  <= loud ? {1'b0, item.adc_sample - thr_reg} : 13'd0;
            div_reg  <= 12'(srwp_pkg::ADC_MAX) - thr_reg;
            quo_reg  <= '0;
        end
        else if (state_reg == ST_CALC)
        begin
            rem_reg <= {rem_sub[11:0], 1'b0};
            quo_reg <= {quo_reg[11:0], rem_ge};
            if (cnt_reg == 4'd0)
                prod_reg <= 27'(samp_reg) * 27'(srwp_pkg::HUE_FULL);
            if (cnt_reg == 4'd1)
                est_reg <= 16'((40'(prod_reg) * 40'(srwp_pkg::ADC_MAX + 2)) >> 24);
            if (cnt_reg == 4'd2)
                hue_reg <= ((prod_reg - est_back) >= 27'(srwp_pkg::ADC_MAX))
                           ? 15'(est_reg + 16'd1) : est_reg[14:0];
        end
    end

endmodule

// ===== hw/rtl/srwp_back.sv =====
// Back part: pixel sequencer and per-pixel colour pipeline feeding the result queue
module srwp_back #(
    parameter int GRID_WIDTH  = 5,
    parameter int GRID_HEIGHT = 5,
    parameter int FRAME_COUNT = 10,
    parameter int OQ_DEPTH    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                jq_empty,
    input  srwp_pkg::job_t      jq_data,
    output logic                jq_rd,
    output logic                oq_wr,
    output srwp_pkg::result_t   oq_data,
    input  logic                oq_pop
);
    localparam int NPIX = GRID_WIDTH * GRID_HEIGHT;
    localparam int PW   = $clog2(NPIX);
    localparam int FW   = $clog2(FRAME_COUNT);
    localparam int OW   = $clog2(OQ_DEPTH + 1);

    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    logic [11:0] wave_rom [FRAME_COUNT][NPIX];
    logic [14:0] hoff_rom [NPIX];

    for (genvar p = 0; p < NPIX; p++)
    begin : g_pix
        localparam int PX = p % GRID_WIDTH;
        localparam int PY = p / GRID_WIDTH;
        localparam int DX = 2 * PX - GRID_WIDTH;
        localparam int DY = 2 * PY - GRID_HEIGHT;
        localparam int unsigned DIST =
            srwp_pkg::isqrt_c(32'(DX * DX + DY * DY) * srwp_pkg::DIST_SCALE);
        assign hoff_rom[p] = 15'((DIST * 15) >> 1);
        for (genvar f = 0; f < FRAME_COUNT; f++)
        begin : g_frm
            localparam longint FT = (longint'(f) * srwp_pkg::FRAME_ANGLE_SUM) / FRAME_COUNT;
            localparam logic [11:0] WV =
                srwp_pkg::wave_c(longint'(DIST) * srwp_pkg::DIST_TO_ANGLE - FT);
            assign wave_rom[f][p] = WV;
        end
    end

    logic             run_reg;
    srwp_pkg::job_t   job_reg;
    logic [PW-1:0]    pix_reg;
    logic [OW-1:0]    occ_reg;
    logic             issue;
    logic             pix_last;
    logic [7:0]       pix8;
    logic [4:0]       v_reg;

    // stage registers
    logic [11:0] wave1_reg, int1_reg;
    logic [15:0] sum1_reg;
    logic [11:0] val2_reg;
    logic [14:0] hue2_reg;
    logic [19:0] vm3_reg;
    logic [11:0] t3_reg;
    logic [2:0]  sec3_reg, sec4_reg, sec5_reg;
    logic [7:0]  c4_reg, c5_reg;
    logic [11:0] m4_reg, m5_reg;
    logic [7:0]  qe5_reg;
    logic [4:0]  idx_reg [5];
    logic        last_reg [5];

    logic [2:0]  sec_c;
    logic [14:0] base_c;
    logic [11:0] frac_c;
    logic [11:0] qe15;
    logic [7:0]  xc;

    assign pix_last = (pix_reg == PW'(NPIX - 1));
    assign issue    = run_reg && (occ_reg < OW'(OQ_DEPTH));
    assign jq_rd    = !run_reg && !jq_empty;
    assign pix8     = 8'(pix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pix_reg <= '0;
            occ_reg <= '0;
            v_reg   <= '0;
        end
        else
        begin
            if (jq_rd)
            begin
                run_reg <= 1'b1;
                pix_reg <= '0;
            end
            else if (issue)
            begin
                if (pix_last)
                    run_reg <= 1'b0;
                else
                    pix_reg <= pix_reg + 1'b1;
            end
            if (issue && !oq_pop)
                occ_reg <= occ_reg + 1'b1;
            else if (oq_pop && !issue)
                occ_reg <= occ_reg - 1'b1;
            v_reg <= {v_reg[3:0], issue};
        end
    end

    // Sector and offset within sector of the hue
    always_comb
    begin
        priority if (hue2_reg >= 15'(5 * srwp_pkg::HUE_SECTOR))
        begin
            sec_c = SEC_MAG_RED; base_c = 15'(5 * srwp_pkg::HUE_SECTOR);
        end
        else if (hue2_reg >= 15'(4 * srwp_pkg::HUE_SECTOR))
        begin
            sec_c = SEC_BLU_MAG; base_c = 15'(4 * srwp_pkg::HUE_SECTOR);
        end
        else if (hue2_reg >= 15'(3 * srwp_pkg::HUE_SECTOR))
        begin
            sec_c = SEC_CYN_BLU; base_c = 15'(3 * srwp_pkg::HUE_SECTOR);
        end
        else if (hue2_reg >= 15'(2 * srwp_pkg::HUE_SECTOR))
        begin
            sec_c = SEC_GRN_CYN; base_c = 15'(2 * srwp_pkg::HUE_SECTOR);
        end
        else if (hue2_reg >= 15'(srwp_pkg::HUE_SECTOR))
        begin
            sec_c = SEC_YEL_GRN; base_c = 15'(srwp_pkg::HUE_SECTOR);
        end
        else
        begin
            sec_c = SEC_RED_YEL; base_c = '0;
        end
    end
    assign frac_c = 12'(hue2_reg - base_c);

    always_ff @(posedge clk)
    begin
        // stage 1: table lookups
        wave1_reg   <= wave_rom[job_reg.frame[FW-1:0]][pix_reg];
        int1_reg    <= job_reg.intensity;
        sum1_reg    <= {1'b0, job_reg.sample_hue} + {1'b0, hoff_rom[pix_reg]};
        idx_reg[0]  <= pix8[4:0];
        last_reg[0] <= pix_last;
        // stage 2: scale by intensity, wrap hue
        val2_reg <= 12'((24'(wave1_reg) * 24'(int1_reg)) >> 12);
        hue2_reg <= (sum1_reg >= 16'(srwp_pkg::HUE_FULL))
                    ? 15'(sum1_reg - 16'(srwp_pkg::HUE_FULL)) : sum1_reg[14:0];
        // stage 3: sector, ramp, value times 255
        sec3_reg <= sec_c;
        t3_reg   <= sec_c[0] ? 12'(srwp_pkg::HUE_SECTOR) - frac_c : frac_c;
        vm3_reg  <= 20'(val2_reg) * 20'(255);
        // stage 4: chroma and ramp product
        sec4_reg <= sec3_reg;
        c4_reg   <= vm3_reg[19:12];
        m4_reg   <= 12'((32'(vm3_reg) * 32'(t3_reg)) >> 20);
        // stage 5: reciprocal estimate of division by 15
        sec5_reg <= sec4_reg;
        c5_reg   <= c4_reg;
        m5_reg   <= m4_reg;
        qe5_reg  <= 8'((24'(m4_reg) * 24'(4369)) >> 16);
        for (int i = 1; i < 5; i++)
        begin
            idx_reg[i]  <= idx_reg[i-1];
            last_reg[i] <= last_reg[i-1];
        end
        if (jq_rd)
            job_reg <= jq_data;
    end

    // correct the estimate once and place the channels
    assign qe15 = 12'(qe5_reg) * 12'(15);
    assign xc   = ((m5_reg - qe15) >= 12'd15) ? qe5_reg + 8'd1 : qe5_reg;

    assign oq_wr = v_reg[4];

    always_comb
    begin
        oq_data.pixel_index = idx_reg[4];
        oq_data.last_pixel  = last_reg[4];
        oq_data.red         = '0;
        oq_data.green       = '0;
        oq_data.blue        = '0;
        unique case (sec5_reg)
            SEC_RED_YEL: begin oq_data.red   = c5_reg; oq_data.green = xc; end
            SEC_YEL_GRN: begin oq_data.red   = xc;     oq_data.green = c5_reg; end
            SEC_GRN_CYN: begin oq_data.green = c5_reg; oq_data.blue  = xc; end
            SEC_CYN_BLU: begin oq_data.green = xc;     oq_data.blue  = c5_reg; end
            SEC_BLU_MAG: begin oq_data.red   = xc;     oq_data.blue  = c5_reg; end
            default:     begin oq_data.red   = c5_reg; oq_data.blue  = xc; end
        endcase
    end

endmodule

// ===== hw/rtl/sound_reactive_wave_pixels.sv =====
// Top level of the sound reactive wave pixel block
//
// Each accepted microphone sample produces GRID_WIDTH*GRID_HEIGHT pixel
// transactions in raster order, the last one flagged by last_pixel. The front
// part takes a sample and then runs a restoring divider for the loudness
// intensity (one quotient bit a cycle), computing the base hue alongside,
// before it hands a job to a two-entry queue; it can take the next sample as
// soon as that job is queued. The back part emits one pixel a cycle, while the
// result queue has room for it, through a five-stage colour pipeline into an
// eight-entry result queue, and loads the next job only after the last pixel
// of the current one has been issued. The wave levels and hue offsets per
// pixel and frame are fixed tables built from the grid and frame parameters.
// Configuration writes are always ready and should be issued only while no
// sample is in progress.
module sound_reactive_wave_pixels #(
    parameter int GRID_WIDTH  = 5,
    parameter int GRID_HEIGHT = 5,
    parameter int FRAME_COUNT = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  srwp_pkg::item_t     item,
    output logic                empty,
    input  logic                pop,
    output srwp_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int OQ_DEPTH = 8;

    // job queue wiring
    logic              jq_wr;
    logic              jq_full;
    logic              jq_rd;
    logic              jq_empty;
    srwp_pkg::job_t    jq_wdata;
    srwp_pkg::job_t    jq_rdata;

    // result queue wiring
    logic              oq_wr;
    logic              oq_pop;
    srwp_pkg::result_t oq_wdata;

    assign cfg_ready = 1'b1;
    assign oq_pop    = pop && !empty;

    // front: classify the sample, update arming state, build the job
    srwp_front #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .jq_wr     (jq_wr),
        .jq_data   (jq_wdata),
        .jq_full   (jq_full)
    );

    // decouple front and back so each can stall on its own
    srwp_fifo #(
        .WIDTH ($bits(srwp_pkg::job_t)),
        .DEPTH (2)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (jq_wr),
        .wr_data (jq_wdata),
        .full    (jq_full),
        .rd_en   (jq_rd),
        .rd_data (jq_rdata),
        .empty   (jq_empty)
    );

    // back: sweep the grid and colour each pixel
    srwp_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .FRAME_COUNT (FRAME_COUNT),
        .OQ_DEPTH    (OQ_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .jq_empty (jq_empty),
        .jq_data  (jq_rdata),
        .jq_rd    (jq_rd),
        .oq_wr    (oq_wr),
        .oq_data  (oq_wdata),
        .oq_pop   (oq_pop)
    );

    // hold finished pixels until the consumer pops them
    srwp_fifo #(
        .WIDTH ($bits(srwp_pkg::result_t)),
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_wr),
        .wr_data (oq_wdata),
        .full    (),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ===== hw/rtl/srwp_checker.sv =====
// Port-level checker for the sound reactive wave pixel block, with its bind
`include "sound_reactive_wave_pixels_assert.svh"

module srwp_checker #(
    parameter int GRID_WIDTH  = 5,
    parameter int GRID_HEIGHT = 5
) (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input srwp_pkg::result_t result
);
    localparam int NPIX = GRID_WIDTH * GRID_HEIGHT;
    localparam int EW   = $clog2(NPIX);

    logic [EW-1:0] exp_reg;
    logic [7:0]    exp8;
    logic          out_take;

    assign out_take = pop && !empty;
    assign exp8     = 8'(exp_reg);

    // track the raster position the next transaction should carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_reg <= '0;
        else if (out_take)
            exp_reg <= (exp_reg == EW'(NPIX - 1)) ? '0 : exp_reg + 1'b1;
    end

    `SRWP_ASSERT_IMPL(a_raster_order, out_take, result.pixel_index == exp8[4:0], "pixel out of raster order")
    `SRWP_ASSERT_IMPL(a_last_flag, out_take, result.last_pixel == (exp_reg == EW'(NPIX - 1)), "last_pixel misplaced")
    `SRWP_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

bind sound_reactive_wave_pixels srwp_checker #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
) u_srwp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
